// File: rtl/bcpd_pkg.sv
// bcpd_pkg: shared types and constants of the command packet deframer
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package bcpd_pkg;

   // header layout and sync marker
   localparam logic [7:0] SYNC_BYTE    = 8'h80;
   localparam int         CNT_W        = 12;
   localparam int         LEN_W        = 11;
   localparam int         OUT_LEN_W    = 6;

   // byte counter positions inside a frame
   localparam logic [CNT_W-1:0] POS_TYPE    = 12'd0;
   localparam logic [CNT_W-1:0] POS_LOW     = 12'd1;
   localparam logic [CNT_W-1:0] POS_CLASS   = 12'd2;
   localparam logic [CNT_W-1:0] POS_CMD     = 12'd3;
   localparam logic [CNT_W-1:0] POS_PAYLOAD = 12'd4;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       resync;
   } req_type;

   typedef struct packed {
      logic [7:0]           type_high_len;
      logic [7:0]           msg_class;
      logic [7:0]           msg_command;
      logic [OUT_LEN_W-1:0] payload_length;
      logic [OUT_LEN_W-1:0] byte_index;
      logic [7:0]           payload_byte;
      logic                 last;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/bcpd_channels.sv
// bcpd_req_if / bcpd_rsp_if: valid/ready channels of the deframer
// depends on bcpd_pkg for the payload types
`default_nettype none

interface bcpd_req_if;
   logic              valid;
   logic              ready;
   bcpd_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bcpd_rsp_if;
   logic              valid;
   logic              ready;
   bcpd_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/ble_command_packet_deframer.sv
// ble_command_packet_deframer: frame splitter for a radio module byte link
// depends on bcpd_pkg, bcpd_channels (bcpd_req_if, bcpd_rsp_if) and bcpd_ram
//
// Usage: each request on req_chan carries one received byte and a resync
// flag. After reset, or on a request with resync set, bytes are dropped
// until 0x80 arrives, which opens a frame: four header bytes, then the
// payload whose 11-bit length comes from the header. Payloads of up to
// PAYLOAD_MAX bytes are written into a payload ram as they arrive; longer
// frames are counted through and dropped. A zero-length frame gives one
// result on rsp_chan in the cycle after its last header byte.
// Throughput: while idle and with the output register free, one request is
// taken every cycle. After the last payload byte the frame is read back
// from the ram one result at a time (read issue, then load into the output
// register), and req_chan is held off until the last result is loaded; the
// registered read of the payload ram is why each result needs both steps.
// The first result passes the issue state, load state and output register.
// When the receiver stalls, the output register holds its result and the
// readout pauses. Reset restores sync hunting and clears the header state
// at once; the payload ram needs no clearing pass.
`default_nettype none

module ble_command_packet_deframer #(
   parameter int PAYLOAD_MAX = 60
) (
   input wire logic   clock,
   input wire logic   reset,
   bcpd_req_if.sink   req_chan,
   bcpd_rsp_if.source rsp_chan
);
   import bcpd_pkg::*;

   localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ISSUE = 2'd1;
   localparam logic [1:0] ST_LOAD  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             sync_wait_ff, sync_wait_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       hdr_type_ff, hdr_type_in;
   logic [7:0]       hdr_low_ff, hdr_low_in;
   logic [7:0]       hdr_class_ff, hdr_class_in;
   logic [7:0]       hdr_cmd_ff, hdr_cmd_in;
   logic [LEN_W-1:0] flen_ff, flen_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_ff, out_in;

   logic             req_fire;
   logic             out_free;
   logic             hunting;
   logic [CNT_W-1:0] cnt_eff;
   logic [CNT_W-1:0] cnt_off;
   logic [LEN_W-1:0] hdr_len;
   logic             fits;
   logic             frame_end;
   logic             last_c;
   logic             wr_en;
   logic             rd_en;
   logic [7:0]       rd_data;
   logic [7:0]       rx_b;

   assign rx_b      = req_chan.payload.rx_byte;
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;

   // sync hunt and effective byte position for this request
   assign hunting   = sync_wait_ff || req_chan.payload.resync;
   assign cnt_eff   = hunting ? POS_TYPE : cnt_ff;
   assign cnt_off   = cnt_eff - POS_PAYLOAD;
   assign hdr_len   = {hdr_type_ff[2:0], hdr_low_ff};
   assign fits      = flen_ff <= LEN_W'(PAYLOAD_MAX);
   assign frame_end = cnt_eff == (CNT_W'(flen_ff) + CNT_W'(3));
   assign last_c    = {{(LEN_W-AW){1'b0}}, rd_idx_ff} == (flen_ff - LEN_W'(1));

   // request parsing and readout sequencer
   always_comb begin
      state_in     = state_ff;
      sync_wait_in = sync_wait_ff;
      cnt_in       = cnt_ff;
      hdr_type_in  = hdr_type_ff;
      hdr_low_in   = hdr_low_ff;
      hdr_class_in = hdr_class_ff;
      hdr_cmd_in   = hdr_cmd_ff;
      flen_in      = flen_ff;
      rd_idx_in    = rd_idx_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (hunting && (rx_b != SYNC_BYTE)) begin
                  sync_wait_in = 1'b1;
                  cnt_in       = req_chan.payload.resync ? POS_TYPE : cnt_ff;
               end else begin
                  sync_wait_in = 1'b0;
                  unique case (cnt_eff)
                     POS_TYPE: begin
                        hdr_type_in = rx_b;
                        cnt_in      = POS_LOW;
                     end
                     POS_LOW: begin
                        hdr_low_in = rx_b;
                        cnt_in     = POS_CLASS;
                     end
                     POS_CLASS: begin
                        hdr_class_in = rx_b;
                        cnt_in       = POS_CMD;
                     end
                     POS_CMD: begin
                        hdr_cmd_in = rx_b;
                        flen_in    = hdr_len;
                        if (hdr_len == '0) begin
                           cnt_in       = POS_TYPE;
                           out_valid_in = 1'b1;
                           out_in.type_high_len  = hdr_type_ff;
                           out_in.msg_class      = hdr_class_ff;
                           out_in.msg_command    = rx_b;
                           out_in.payload_length = '0;
                           out_in.byte_index     = '0;
                           out_in.payload_byte   = '0;
                           out_in.last           = 1'b1;
                        end else begin
                           cnt_in = POS_PAYLOAD;
                        end
                     end
                     default: begin
                        wr_en = fits;
                        if (frame_end) begin
                           cnt_in    = POS_TYPE;
                           rd_idx_in = '0;
                           if (fits) begin
                              state_in = ST_ISSUE;
                           end
                        end else begin
                           cnt_in = cnt_eff + CNT_W'(1);
                        end
                     end
                  endcase
               end
            end
         end
         ST_ISSUE: begin
            if (out_free) begin
               rd_en    = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            out_valid_in          = 1'b1;
            out_in.type_high_len  = hdr_type_ff;
            out_in.msg_class      = hdr_class_ff;
            out_in.msg_command    = hdr_cmd_ff;
            out_in.payload_length = flen_ff[OUT_LEN_W-1:0];
            out_in.byte_index     = OUT_LEN_W'(rd_idx_ff);
            out_in.payload_byte   = rd_data;
            out_in.last           = last_c;
            if (last_c) begin
               state_in = ST_IDLE;
            end else begin
               rd_idx_in = AW'(rd_idx_ff + 1'b1);
               state_in  = ST_ISSUE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sync_wait_ff <= 1'b1;
         cnt_ff       <= '0;
         hdr_type_ff  <= '0;
         hdr_low_ff   <= '0;
         hdr_class_ff <= '0;
         hdr_cmd_ff   <= '0;
         flen_ff      <= '0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sync_wait_ff <= sync_wait_in;
         cnt_ff       <= cnt_in;
         hdr_type_ff  <= hdr_type_in;
         hdr_low_ff   <= hdr_low_in;
         hdr_class_ff <= hdr_class_in;
         hdr_cmd_ff   <= hdr_cmd_in;
         flen_ff      <= flen_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // payload store
   bcpd_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_MAX)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_off[AW-1:0]),
      .wr_data (rx_b),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

`ifndef SYNTHESIS
   // no ram write while a frame is being read back
   a_no_write_in_readout: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_IDLE))
      else $error("payload ram written during readout");

   // a load always finds the output register empty
   a_load_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> !out_valid_ff)
      else $error("output register busy at load");

   // a read issue is followed by its load
   a_issue_then_load: assert property (@(posedge clock) disable iff (reset)
      rd_en |=> (state_ff == ST_LOAD))
      else $error("read issue not followed by load");

   // the final result of a frame returns the sequencer to idle
   a_last_ends_readout: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LOAD) && last_c) |=> (state_ff == ST_IDLE) && rsp_chan.payload.last)
      else $error("readout did not end on last result");
`endif

endmodule

`default_nettype wire

// File: rtl/bcpd_ram.sv
// bcpd_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bcpd_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 60,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
